// ===== hdl/kepsu_pkg.sv =====
// kepsu_pkg: shared constants for the k-epsilon node update pipeline.
// Widths, fixed-point formats, stage latencies and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kepsu_pkg;

  // Value formats
  localparam int WORD_W        = 64;   // k, eps, viscosity
  localparam int WIDE_W        = 128;  // products and quotients
  localparam int COEF_W        = 32;   // c_mu, c2 (Q8.24)
  localparam int DT_W          = 48;   // dt (Q8.40)
  localparam int COEF_FRAC     = 24;
  localparam int DT_FRAC       = 40;
  localparam int FRACTION_BITS = 40;

  // Multiplier operand of the scaling unit, wide enough for dt
  localparam int SCALE_M_W = DT_W;

  // Stage latencies
  localparam int IN_LAT    = 1;
  localparam int MUL_LAT   = 2;
  localparam int DIV_LAT   = WIDE_W;
  localparam int SCALE_LAT = 4;
  localparam int OUT_LAT   = 1;
  localparam int PIPE_DEPTH = IN_LAT + MUL_LAT + DIV_LAT + 2 * SCALE_LAT + OUT_LAT;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VISC_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DISS_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIME_STEP = 2'd2;

  // Reset values
  localparam logic [COEF_W-1:0] VISC_COEF_RST = 32'd1509949;
  localparam logic [COEF_W-1:0] DISS_COEF_RST = 32'd32212255;
  localparam logic [DT_W-1:0]   TIME_STEP_RST = 48'd1099511628;

endpackage
`default_nettype wire

// ===== hdl/kepsu_delay.sv =====
// kepsu_delay: enabled shift line that aligns side data with the datapath.
// Depends on nothing but the stall enable from the top level.
`timescale 1ns / 1ps
`default_nettype none
module kepsu_delay #(
  parameter int W     = 64,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] tap_r [0:DEPTH-1];

  // Shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule
`default_nettype wire

// ===== hdl/kepsu_mul.sv =====
// kepsu_mul: 64x64 unsigned multiplier in two stages (32x32 partial
// products, then one sum). Uses kepsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kepsu_mul (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [kepsu_pkg::WORD_W-1:0]  a,
  input  wire logic [kepsu_pkg::WORD_W-1:0]  b,
  output logic      [kepsu_pkg::WIDE_W-1:0]  prod
);
  import kepsu_pkg::*;

  localparam int HW = WORD_W / 2;

  logic [WORD_W-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [WIDE_W-1:0] prod_r, prod_nxt;

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[HW-1:0]  * b[HW-1:0];
      lh_r <= a[HW-1:0]  * b[WORD_W-1:HW];
      hl_r <= a[WORD_W-1:HW] * b[HW-1:0];
      hh_r <= a[WORD_W-1:HW] * b[WORD_W-1:HW];
    end
  end

  // Stage 2: combine
  always_comb begin
    prod_nxt = {hh_r, ll_r}
             + {{HW{1'b0}}, lh_r, {HW{1'b0}}}
             + {{HW{1'b0}}, hl_r, {HW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ===== hdl/kepsu_div.sv =====
// kepsu_div: pipelined restoring divider, 128-bit dividend by 64-bit
// divisor, one quotient bit per stage. Carries the divisor out. Uses kepsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kepsu_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [kepsu_pkg::WIDE_W-1:0]  num,
  input  wire logic [kepsu_pkg::WORD_W-1:0]  den,
  output logic      [kepsu_pkg::WIDE_W-1:0]  quo,
  output logic      [kepsu_pkg::WORD_W-1:0]  den_out
);
  import kepsu_pkg::*;

  // Partial remainder, dividend/quotient shift word and divisor per stage
  logic [WORD_W-1:0] rem_a [0:DIV_LAT];
  logic [WIDE_W-1:0] nq_a  [0:DIV_LAT];
  logic [WORD_W-1:0] den_a [0:DIV_LAT];

  assign rem_a[0] = '0;
  assign nq_a[0]  = num;
  assign den_a[0] = den;

  for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
    logic [WORD_W-1:0] rem_r, rem_nxt;
    logic [WIDE_W-1:0] nq_r, nq_nxt;
    logic [WORD_W-1:0] den_r;
    logic [WORD_W:0]   trial;
    logic              ge;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
      trial   = {rem_a[s], nq_a[s][WIDE_W-1]};
      ge      = (trial >= {1'b0, den_a[s]});
      rem_nxt = ge ? WORD_W'(trial - {1'b0, den_a[s]}) : trial[WORD_W-1:0];
      nq_nxt  = {nq_a[s][WIDE_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        nq_r  <= nq_nxt;
        den_r <= den_a[s];
      end
    end

    assign rem_a[s+1] = rem_r;
    assign nq_a[s+1]  = nq_r;
    assign den_a[s+1] = den_r;
  end

  assign quo     = nq_a[DIV_LAT];
  assign den_out = den_a[DIV_LAT];

endmodule
`default_nettype wire

// ===== hdl/kepsu_scale.sv =====
// kepsu_scale: floor(a*m / 2^SH) saturated to 64 bits, four stages
// (32x24 partial products, two partial sums, final sum, shift/clip). Uses kepsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kepsu_scale #(
  parameter int SH = kepsu_pkg::COEF_FRAC
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [kepsu_pkg::WIDE_W-1:0]     a,
  input  wire logic [kepsu_pkg::SCALE_M_W-1:0]  m,
  output logic      [kepsu_pkg::WORD_W-1:0]     res,
  output logic                                  over
);
  import kepsu_pkg::*;

  localparam int AW     = 32;
  localparam int MH     = SCALE_M_W / 2;
  localparam int NA     = WIDE_W / AW;
  localparam int PP_W   = AW + MH;
  localparam int HALF_W = WIDE_W + MH;
  localparam int PROD_W = WIDE_W + SCALE_M_W;

  logic [PP_W-1:0]   pp_r [0:2*NA-1];
  logic [HALF_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [WORD_W-1:0] res_r;
  logic              over_r, over_nxt;

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        pp_r[2*i]   <= a[AW*i +: AW] * m[MH-1:0];
        pp_r[2*i+1] <= a[AW*i +: AW] * m[SCALE_M_W-1:MH];
      end
    end
  end

  // Stage 2: sum per multiplier half
  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      lo_nxt = lo_nxt + (HALF_W'(pp_r[2*i])   << (AW*i));
      hi_nxt = hi_nxt + (HALF_W'(pp_r[2*i+1]) << (AW*i));
    end
  end

  // Stage 3: full product
  always_comb begin
    prod_nxt = PROD_W'(lo_r) + (PROD_W'(hi_r) << MH);
  end

  // Stage 4: drop fraction, clip to all ones
  always_comb begin
    over_nxt = |(prod_r >> (SH + WORD_W));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      prod_r <= prod_nxt;
      over_r <= over_nxt;
      res_r  <= over_nxt ? {WORD_W{1'b1}} : prod_r[SH +: WORD_W];
    end
  end

  assign res  = res_r;
  assign over = over_r;

endmodule
`default_nettype wire

// ===== hdl/k_epsilon_node_update.sv =====
// k_epsilon_node_update: top level of the k-epsilon node update pipeline.
// Instantiates kepsu_mul, kepsu_div, kepsu_scale and kepsu_delay; uses kepsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One mesh node enters per cycle and passes 140 register stages (1 input
// stage, 2 multiplier stages, 128 divider stages of one quotient bit each,
// two chained 4-stage scaling units, 1 output stage). The input stage loads
// at the input transaction's own edge. Throughput is one node per clock
// whenever the output side takes results; a held result stalls the whole
// pipeline and in_tready follows. Inputs k and eps are raised to the floor
// round(2^F/1e10) first. Coefficients and time step may be written only
// while no transaction is in flight.
module k_epsilon_node_update #(
  parameter int FRACTION_BITS = kepsu_pkg::FRACTION_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // in_tdata: kinetic_energy [63:0], dissipation_rate [127:64]
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [2*kepsu_pkg::WORD_W-1:0]        in_tdata,
  // out_tdata: eddy_viscosity [63:0], next_kinetic_energy [127:64],
  //            next_dissipation_rate [191:128]
  // out_tuser: viscosity_saturated [0], energy_floored [1],
  //            dissipation_floored [2]
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic      [3*kepsu_pkg::WORD_W-1:0]        out_tdata,
  output logic      [2:0]                            out_tuser,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [kepsu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [kepsu_pkg::DT_W-1:0]            cfg_wdata
);
  import kepsu_pkg::*;

  localparam logic [WORD_W-1:0] FLOOR_RAW =
    ((WORD_W'(1) << FRACTION_BITS) + 64'd5000000000) / 64'd10000000000;
  localparam logic [WORD_W-1:0] FLOOR = (FLOOR_RAW == '0) ? WORD_W'(1) : FLOOR_RAW;
  localparam int RAW_DLY  = MUL_LAT + DIV_LAT + 2 * SCALE_LAT;
  localparam int SIDE_DLY = 2 * SCALE_LAT;

  logic              en;
  logic [PIPE_DEPTH-1:0] vld_r;

  logic [COEF_W-1:0] visc_coef_r;
  logic [COEF_W-1:0] diss_coef_r;
  logic [DT_W-1:0]   time_step_r;

  logic [WORD_W-1:0] k_in, e_in;
  logic [WORD_W-1:0] kf_r, ef_r, kraw_r, eraw_r;
  logic [WORD_W-1:0] kf_d2, ef_d2;
  logic [WIDE_W-1:0] kk, ee;
  logic [WIDE_W-1:0] q_visc, q_ratio;
  logic [WORD_W-1:0] ef_div, kf_div;
  logic [WORD_W-1:0] nu, dk, s_diss, de;
  logic              nu_over;
  logic [WORD_W-1:0] nu_d, dk_d, kf_d, ef_d, kraw_d, eraw_d;
  logic              sat_d;

  logic [WORD_W-1:0] kn_nxt, en_nxt;
  logic              kflag_nxt, eflag_nxt;
  logic [3*WORD_W-1:0] tdata_r;
  logic [2:0]        tuser_r;

  // Advance when the output slot is empty or being taken
  assign en        = !vld_r[PIPE_DEPTH-1] || out_tready;
  assign in_tready = en;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visc_coef_r <= VISC_COEF_RST;
      diss_coef_r <= DISS_COEF_RST;
      time_step_r <= TIME_STEP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_VISC_COEF: visc_coef_r <= cfg_wdata[COEF_W-1:0];
        CFG_IDX_DISS_COEF: diss_coef_r <= cfg_wdata[COEF_W-1:0];
        CFG_IDX_TIME_STEP: time_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage: floor k and eps, keep the raw values
  assign k_in = in_tdata[WORD_W-1:0];
  assign e_in = in_tdata[2*WORD_W-1:WORD_W];

  always_ff @(posedge clk) begin
    if (en) begin
      kf_r   <= (k_in < FLOOR) ? FLOOR : k_in;
      ef_r   <= (e_in < FLOOR) ? FLOOR : e_in;
      kraw_r <= k_in;
      eraw_r <= e_in;
    end
  end

  // Squares
  kepsu_mul u_mul_kk (.clk(clk), .en(en), .a(kf_r), .b(kf_r), .prod(kk));
  kepsu_mul u_mul_ee (.clk(clk), .en(en), .a(ef_r), .b(ef_r), .prod(ee));

  kepsu_delay #(.W(2*WORD_W), .DEPTH(MUL_LAT)) u_dly_div_den (
    .clk(clk), .en(en), .din({kf_r, ef_r}), .dout({kf_d2, ef_d2})
  );

  // k^2/eps and eps^2/k
  kepsu_div u_div_visc (
    .clk(clk), .en(en), .num(kk), .den(ef_d2), .quo(q_visc), .den_out(ef_div)
  );
  kepsu_div u_div_ratio (
    .clk(clk), .en(en), .num(ee), .den(kf_d2), .quo(q_ratio), .den_out(kf_div)
  );

  // Coefficient and time-step scaling
  kepsu_scale #(.SH(COEF_FRAC)) u_scale_nu (
    .clk(clk), .en(en), .a(q_visc), .m(SCALE_M_W'(visc_coef_r)),
    .res(nu), .over(nu_over)
  );
  kepsu_scale #(.SH(COEF_FRAC)) u_scale_s (
    .clk(clk), .en(en), .a(q_ratio), .m(SCALE_M_W'(diss_coef_r)),
    .res(s_diss), .over()
  );
  kepsu_scale #(.SH(DT_FRAC)) u_scale_dk (
    .clk(clk), .en(en), .a(WIDE_W'(ef_div)), .m(time_step_r),
    .res(dk), .over()
  );
  kepsu_scale #(.SH(DT_FRAC)) u_scale_de (
    .clk(clk), .en(en), .a(WIDE_W'(s_diss)), .m(time_step_r),
    .res(de), .over()
  );

  // Align side values with the second scaling stage
  kepsu_delay #(.W(2*WORD_W+1), .DEPTH(SCALE_LAT)) u_dly_nu (
    .clk(clk), .en(en), .din({nu_over, nu, dk}), .dout({sat_d, nu_d, dk_d})
  );
  kepsu_delay #(.W(2*WORD_W), .DEPTH(SIDE_DLY)) u_dly_floored (
    .clk(clk), .en(en), .din({kf_div, ef_div}), .dout({kf_d, ef_d})
  );
  kepsu_delay #(.W(2*WORD_W), .DEPTH(RAW_DLY)) u_dly_raw (
    .clk(clk), .en(en), .din({kraw_r, eraw_r}), .dout({kraw_d, eraw_d})
  );

  // Euler step, floor and bypass for a zero time step
  always_comb begin
    kflag_nxt = 1'b0;
    eflag_nxt = 1'b0;
    if (time_step_r == '0) begin
      kn_nxt = kraw_d;
      en_nxt = eraw_d;
    end else begin
      if (dk_d > kf_d - FLOOR) begin
        kn_nxt    = FLOOR;
        kflag_nxt = 1'b1;
      end else begin
        kn_nxt = kf_d - dk_d;
      end
      if (de > ef_d - FLOOR) begin
        en_nxt    = FLOOR;
        eflag_nxt = 1'b1;
      end else begin
        en_nxt = ef_d - de;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      tdata_r <= {en_nxt, kn_nxt, nu_d};
      tuser_r <= {eflag_nxt, kflag_nxt, sat_d};
    end
  end

  assign out_tvalid = vld_r[PIPE_DEPTH-1];
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

endmodule
`default_nettype wire
